[rtl/end_to_end_retransmit_tracker_top_assert.svh]
// Assertion macros for the retransmit tracker checker.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef END_TO_END_RETRANSMIT_TRACKER_TOP_ASSERT_SVH
`define END_TO_END_RETRANSMIT_TRACKER_TOP_ASSERT_SVH

// same-cycle implication
`define E2E_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("retransmit tracker check failed");

// next-cycle implication
`define E2E_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("retransmit tracker check failed");

`endif

[rtl/e2e_rtt_pkg.sv]
// Shared constants, codes and types of the retransmit tracker.
// No dependencies.
package e2e_rtt_pkg;
   localparam int NUM_DEST    = 16;
   localparam int QUEUE_DEPTH = 8;
   localparam int DW          = $clog2(NUM_DEST);
   localparam int QW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW          = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_DEPTH   = NUM_DEST * QUEUE_DEPTH;
   localparam int AW          = $clog2(MEM_DEPTH);

   localparam logic [15:0] LIMIT_RESET = 16'd1024;

   localparam logic [1:0] FUNC_INJECT = 2'd0;
   localparam logic [1:0] FUNC_ACK    = 2'd1;
   localparam logic [1:0] FUNC_TICK   = 2'd2;

   typedef struct packed {
      logic [15:0] id;
      logic [3:0]  src;
      logic [31:0] stime;
   } entry_type;

   typedef struct packed {
      logic          load;
      logic          rd_en;
      logic [QW-1:0] rd_slot;
      logic          wr_en;
      logic [QW-1:0] wr_slot;
      logic          wr_shift;
      logic [DW-1:0] dest;
      logic          tick_upd;
      logic          fill_inc;
      logic          fill_dec;
      logic          head_inc;
      logic          clr_timer;
      logic          out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0]    func;
      logic          is_ack;
      logic          peer_ok;
      logic [DW-1:0] peer;
      logic [FW-1:0] fill;
      logic          hit;
      logic          emit;
      logic          out_free;
   } sts_type;
endpackage

[rtl/e2e_rtt_ifs.sv]
// Channel interfaces of the retransmit tracker: request, response, register write.
// No dependencies.
interface e2e_rtt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [3:0]  peer;
   logic [15:0] packet_id;
   logic [3:0]  source_addr;
   logic [31:0] start_time;
   logic        is_ack;
   modport source (output valid, func, peer, packet_id, source_addr, start_time, is_ack,
                   input ready);
   modport sink (input valid, func, peer, packet_id, source_addr, start_time, is_ack,
                 output ready);
endinterface

interface e2e_rtt_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] resend_id;
   logic [3:0]  resend_source;
   logic [3:0]  resend_dest;
   logic [31:0] resend_time;
   logic        last;
   modport source (output valid, resend_id, resend_source, resend_dest, resend_time, last,
                   input ready);
   modport sink (input valid, resend_id, resend_source, resend_dest, resend_time, last,
                 output ready);
endinterface

interface e2e_rtt_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[rtl/e2e_rtt_datapath.sv]
// Datapath: entry memory, per-destination fill, head and timer, limit register, output register.
// Depends on e2e_rtt_pkg.
module e2e_rtt_datapath import e2e_rtt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_func,
   input  logic [3:0]  req_peer,
   input  logic [15:0] req_packet_id,
   input  logic [3:0]  req_source_addr,
   input  logic [31:0] req_start_time,
   input  logic        req_is_ack,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_resend_id,
   output logic [3:0]  rsp_resend_source,
   output logic [3:0]  rsp_resend_dest,
   output logic [31:0] rsp_resend_time,
   output logic        rsp_last
);
   logic [1:0]    func_ff;
   logic [3:0]    peer_ff;
   logic          is_ack_ff;
   entry_type     item_ff;
   logic [15:0]   limit_ff;
   logic [FW-1:0] fill_ff [NUM_DEST];
   logic [QW-1:0] head_ff [NUM_DEST];
   logic [15:0]   cnt_ff  [NUM_DEST];
   logic [15:0]   cnt_in  [NUM_DEST];
   logic [NUM_DEST-1:0] expire_in;
   logic [NUM_DEST-1:0] emit_ff;
   entry_type     mem [MEM_DEPTH];
   entry_type     rd_ff;
   entry_type     wr_data;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          rsp_valid_ff;
   entry_type     out_ff;
   logic [3:0]    out_dest_ff;
   logic          out_last_ff;
   logic          higher;
   logic [QW-1:0] head_cur;

   function automatic logic [AW-1:0] slot_addr(logic [DW-1:0] dest, logic [QW-1:0] head,
                                                logic [QW-1:0] slot);
      logic [QW:0] sum;
      sum = {1'b0, head} + {1'b0, slot};
      if (sum >= (QW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (QW+1)'(QUEUE_DEPTH);
      end
      return AW'(dest) * AW'(QUEUE_DEPTH) + AW'(sum);
   endfunction

   assign head_cur  = head_ff[cmd.dest];
   assign rd_addr   = slot_addr(cmd.dest, head_cur, cmd.rd_slot);
   assign wr_addr   = slot_addr(cmd.dest, head_cur, cmd.wr_slot);
   assign wr_data   = cmd.wr_shift ? rd_ff : item_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      for (int i = 0; i < NUM_DEST; i++) begin
         cnt_in[i]    = cnt_ff[i] + 16'd1;
         expire_in[i] = (cnt_in[i] >= limit_ff);
      end
   end

   // last resend of the tick when no later destination emits
   always_comb begin
      higher = 1'b0;
      for (int i = 0; i < NUM_DEST; i++) begin
         if (i > int'(cmd.dest) && emit_ff[i]) begin
            higher = 1'b1;
         end
      end
   end

   assign sts.func     = func_ff;
   assign sts.is_ack   = is_ack_ff;
   assign sts.peer_ok  = (32'(peer_ff) < NUM_DEST);
   assign sts.peer     = DW'(peer_ff);
   assign sts.fill     = fill_ff[DW'(peer_ff)];
   assign sts.hit      = (rd_ff.id == item_ff.id);
   assign sts.emit     = emit_ff[cmd.dest];
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff       <= req_func;
         peer_ff       <= req_peer;
         is_ack_ff     <= req_is_ack;
         item_ff.id    <= req_packet_id;
         item_ff.src   <= req_source_addr;
         item_ff.stime <= req_start_time;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.out_load) begin
         out_ff      <= rd_ff;
         out_dest_ff <= 4'(cmd.dest);
         out_last_ff <= !higher;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_DEST; i++) begin
            fill_ff[i] <= '0;
            head_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         if (cmd.tick_upd) begin
            for (int i = 0; i < NUM_DEST; i++) begin
               cnt_ff[i]  <= expire_in[i] ? 16'd0 : cnt_in[i];
               emit_ff[i] <= expire_in[i] && (fill_ff[i] != '0);
            end
         end
         if (cmd.clr_timer) begin
            cnt_ff[cmd.dest] <= '0;
         end
         if (cmd.fill_inc) begin
            fill_ff[cmd.dest] <= fill_ff[cmd.dest] + FW'(1);
         end
         if (cmd.fill_dec) begin
            fill_ff[cmd.dest] <= fill_ff[cmd.dest] - FW'(1);
         end
         if (cmd.head_inc) begin
            head_ff[cmd.dest] <= (head_cur == QW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + QW'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_resend_id     = out_ff.id;
   assign rsp_resend_source = out_ff.src;
   assign rsp_resend_dest   = out_dest_ff;
   assign rsp_resend_time   = out_ff.stime;
   assign rsp_last          = out_last_ff;
endmodule

[rtl/e2e_rtt_ctrl.sv]
// Controller: sequences search, insert, removal and the tick walk over the datapath.
// Depends on e2e_rtt_pkg.
module e2e_rtt_ctrl import e2e_rtt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_SRCH  = 4'd2;
   localparam logic [3:0] S_SCMP  = 4'd3;
   localparam logic [3:0] S_INS   = 4'd4;
   localparam logic [3:0] S_SHRD  = 4'd5;
   localparam logic [3:0] S_SHWR  = 4'd6;
   localparam logic [3:0] S_TUPD  = 4'd7;
   localparam logic [3:0] S_TWALK = 4'd8;
   localparam logic [3:0] S_TRD   = 4'd9;

   localparam logic [DW-1:0] LAST_DEST = DW'(NUM_DEST - 1);

   logic [3:0]    state_ff, state_in;
   logic [FW-1:0] k_ff, k_in;
   logic [DW-1:0] d_ff, d_in;
   logic [FW-1:0] k_next;

   assign k_next    = k_ff + FW'(1);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      d_in     = d_ff;
      cmd      = '0;
      cmd.dest = sts.peer;
      cmd.rd_slot = k_ff[QW-1:0];
      cmd.wr_slot = k_ff[QW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            k_in = '0;
            d_in = '0;
            case (sts.func)
               FUNC_INJECT: state_in = (sts.is_ack || !sts.peer_ok) ? S_IDLE : S_SRCH;
               FUNC_ACK:    state_in = sts.peer_ok ? S_SRCH : S_IDLE;
               FUNC_TICK:   state_in = S_TUPD;
               default:     state_in = S_IDLE;
            endcase
         end
         S_SRCH: begin
            if (k_ff == sts.fill) begin
               if (sts.func == FUNC_INJECT && sts.fill != FW'(QUEUE_DEPTH)) begin
                  state_in = S_INS;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SCMP;
            end
         end
         S_SCMP: begin
            if (!sts.hit) begin
               k_in     = k_next;
               state_in = S_SRCH;
            end else if (sts.func == FUNC_INJECT) begin
               state_in = S_IDLE;
            end else if (k_ff == '0) begin
               // head removal: advance the head pointer
               cmd.head_inc  = 1'b1;
               cmd.fill_dec  = 1'b1;
               cmd.clr_timer = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_SHRD;
            end
         end
         S_SHRD: begin
            if (k_next == sts.fill) begin
               cmd.fill_dec = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_slot = k_next[QW-1:0];
               state_in    = S_SHWR;
            end
         end
         S_SHWR: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_shift = 1'b1;
            k_in         = k_next;
            state_in     = S_SHRD;
         end
         S_INS: begin
            cmd.wr_en     = 1'b1;
            cmd.fill_inc  = 1'b1;
            cmd.clr_timer = (sts.fill == '0);
            state_in      = S_IDLE;
         end
         S_TUPD: begin
            cmd.tick_upd = 1'b1;
            state_in     = S_TWALK;
         end
         S_TWALK: begin
            cmd.dest    = d_ff;
            cmd.rd_slot = '0;
            if (sts.emit) begin
               cmd.rd_en = 1'b1;
               state_in  = S_TRD;
            end else if (d_ff == LAST_DEST) begin
               state_in = S_IDLE;
            end else begin
               d_in = d_ff + DW'(1);
            end
         end
         S_TRD: begin
            cmd.dest = d_ff;
            // hold the read data until the output register frees up
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.head_inc = 1'b1;
               cmd.fill_dec = 1'b1;
               if (d_ff == LAST_DEST) begin
                  state_in = S_IDLE;
               end else begin
                  d_in     = d_ff + DW'(1);
                  state_in = S_TWALK;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         d_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         d_ff     <= d_in;
      end
   end
endmodule

[rtl/end_to_end_retransmit_tracker_top.sv]
// Retransmit tracker: one request at a time. After its transfer an inject or ack
// searches the queued entries one by one, and a mid-queue ack then shifts each later
// entry down by one slot, since the entry memory has one read and one write port.
// An ignored request (ack packet, unused code) goes back to idle after dispatch. A tick
// updates every timer, then walks the destinations, waiting while the response side
// stalls. Resends leave through an output register, in ascending destination order,
// with last set on the final one.
// Depends on e2e_rtt_pkg, the channel interfaces, e2e_rtt_ctrl and e2e_rtt_datapath.
module end_to_end_retransmit_tracker_top import e2e_rtt_pkg::*; (
   input logic     clock,
   input logic     reset,
   e2e_rtt_req_if.sink   req_ch,
   e2e_rtt_rsp_if.source rsp_ch,
   e2e_rtt_csr_if.sink   csr_ch
);
   cmd_type cmd;
   sts_type sts;

   e2e_rtt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   e2e_rtt_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_ch.func),
      .req_peer          (req_ch.peer),
      .req_packet_id     (req_ch.packet_id),
      .req_source_addr   (req_ch.source_addr),
      .req_start_time    (req_ch.start_time),
      .req_is_ack        (req_ch.is_ack),
      .csr_valid         (csr_ch.valid),
      .csr_ready         (csr_ch.ready),
      .csr_data          (csr_ch.data),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_resend_id     (rsp_ch.resend_id),
      .rsp_resend_source (rsp_ch.resend_source),
      .rsp_resend_dest   (rsp_ch.resend_dest),
      .rsp_resend_time   (rsp_ch.resend_time),
      .rsp_last          (rsp_ch.last)
   );
endmodule

[rtl/e2e_rtt_checker.sv]
// Port-level checker of the retransmit tracker, bound to the top level.
// Depends on end_to_end_retransmit_tracker_top_assert.svh.
`include "end_to_end_retransmit_tracker_top_assert.svh"
module e2e_rtt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_resend_id,
   input logic [3:0]  rsp_resend_dest
);
   // one request in flight: no back-to-back request transfer
   `E2E_ASSERT_NXT(a_req_single, req_valid && req_ready, !req_ready)
   `E2E_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `E2E_ASSERT_NXT(a_rsp_stable, rsp_valid && !rsp_ready,
                   $stable(rsp_resend_id) && $stable(rsp_resend_dest))
   // a resend always carries a stored entry
   `E2E_ASSERT_IMP(a_rsp_known, rsp_valid, !$isunknown({rsp_resend_id, rsp_resend_dest}))
endmodule

bind end_to_end_retransmit_tracker_top e2e_rtt_checker u_e2e_rtt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_resend_id   (rsp_ch.resend_id),
   .rsp_resend_dest (rsp_ch.resend_dest)
);

[bench/e2e_rtt_tracker_checker.sv]
// Checker for the retransmit tracker: watches the request, response and register channels,
// keeps its own copy of the pending queues and timers, and compares every resend.
// Depends on e2e_rtt_pkg and the channel interfaces in e2e_rtt_ifs.
module e2e_rtt_tracker_checker import e2e_rtt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   e2e_rtt_req_if   req_ch,
   e2e_rtt_rsp_if   rsp_ch,
   e2e_rtt_csr_if   csr_ch,
   output int       fail_count,
   output int       resends_owed
);
   typedef struct {
      logic [15:0] id;
      logic [3:0]  src;
      logic [3:0]  dest;
      logic [31:0] stime;
      logic        last;
   } resend_type;

   logic [15:0] held_id    [NUM_DEST][QUEUE_DEPTH];
   logic [3:0]  held_src   [NUM_DEST][QUEUE_DEPTH];
   logic [31:0] held_stime [NUM_DEST][QUEUE_DEPTH];
   int          fill       [NUM_DEST];
   logic [15:0] timer      [NUM_DEST];
   logic [15:0] limit;
   resend_type  owed_resends[$];

   function automatic int find_slot(int d, logic [15:0] id);
      for (int k = 0; k < fill[d]; k++)
         if (held_id[d][k] == id) return k;
      return -1;
   endfunction

   function automatic void remove_slot(int d, int pos);
      for (int k = pos; k + 1 < fill[d]; k++) begin
         held_id[d][k]    = held_id[d][k + 1];
         held_src[d][k]   = held_src[d][k + 1];
         held_stime[d][k] = held_stime[d][k + 1];
      end
      fill[d]--;
   endfunction

   // apply one accepted request and queue the resends it causes
   function automatic void track_request(logic [1:0] func, logic [3:0] peer,
                                         logic [15:0] id, logic [3:0] src,
                                         logic [31:0] stime, logic ack_pkt);
      int pos;
      int first;
      int d;
      resend_type r;
      d = peer;
      case (func)
         FUNC_INJECT: begin
            if (!ack_pkt && find_slot(d, id) < 0 && fill[d] < QUEUE_DEPTH) begin
               held_id[d][fill[d]]    = id;
               held_src[d][fill[d]]   = src;
               held_stime[d][fill[d]] = stime;
               fill[d]++;
               if (fill[d] == 1) timer[d] = '0;
            end
         end
         FUNC_ACK: begin
            pos = find_slot(d, id);
            if (pos >= 0) begin
               remove_slot(d, pos);
               if (pos == 0) timer[d] = '0;
            end
         end
         FUNC_TICK: begin
            first = owed_resends.size();
            for (int q = 0; q < NUM_DEST; q++) begin
               timer[q] = timer[q] + 16'd1;
               if (timer[q] >= limit) begin
                  timer[q] = '0;
                  if (fill[q] > 0) begin
                     r.id = held_id[q][0];
                     r.src = held_src[q][0];
                     r.dest = q[3:0];
                     r.stime = held_stime[q][0];
                     r.last = 1'b0;
                     owed_resends.insert(owed_resends.size(), r);
                     remove_slot(q, 0);
                  end
               end
            end
            if (owed_resends.size() > first)
               owed_resends[owed_resends.size() - 1].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      resend_type want;
      if (reset) begin
         for (int d = 0; d < NUM_DEST; d++) begin
            fill[d] = 0;
            timer[d] = '0;
         end
         limit = LIMIT_RESET;
         owed_resends.delete();
         fail_count = 0;
         resends_owed = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) limit = csr_ch.data;
         if (req_ch.valid && req_ch.ready)
            track_request(req_ch.func, req_ch.peer, req_ch.packet_id, req_ch.source_addr,
                          req_ch.start_time, req_ch.is_ack);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_resends.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected resend id %h dest %0d", rsp_ch.resend_id,
                           rsp_ch.resend_dest);
            end else begin
               want = owed_resends.pop_front();
               if (rsp_ch.resend_id !== want.id || rsp_ch.resend_source !== want.src ||
                   rsp_ch.resend_dest !== want.dest || rsp_ch.resend_time !== want.stime ||
                   rsp_ch.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("resend mismatch: exp id %h src %h dest %h time %h last %b,",
                              want.id, want.src, want.dest, want.stime, want.last,
                              " got id %h src %h dest %h time %h last %b",
                              rsp_ch.resend_id, rsp_ch.resend_source, rsp_ch.resend_dest,
                              rsp_ch.resend_time, rsp_ch.last);
               end
            end
         end
         resends_owed = owed_resends.size();
      end
   end
endmodule

[bench/tb_end_to_end_retransmit_tracker_top.sv]
// Testbench top for the retransmit tracker: clock, reset, request and register stimulus,
// random response stalls, and the verdict. Depends on e2e_rtt_pkg, the channel
// interfaces, the block and e2e_rtt_tracker_checker.
module tb_end_to_end_retransmit_tracker_top;
   import e2e_rtt_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   int   fail_count;
   int   resends_owed;
   int   cycle_count;
   int   tx_idle;
   int   rx_idle;

   e2e_rtt_req_if req_ch ();
   e2e_rtt_rsp_if rsp_ch ();
   e2e_rtt_csr_if csr_ch ();

   end_to_end_retransmit_tracker_top dut (
      .clock (clock), .reset (reset), .req_ch (req_ch), .rsp_ch (rsp_ch), .csr_ch (csr_ch)
   );

   e2e_rtt_tracker_checker checker_i (
      .clock (clock), .reset (reset), .req_ch (req_ch), .rsp_ch (rsp_ch), .csr_ch (csr_ch),
      .fail_count (fail_count), .resends_owed (resends_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle);
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_end_to_end_retransmit_tracker_top NOT OK");
         $finish;
      end
   end

   task automatic send_request(logic [1:0] func, logic [3:0] peer, logic [15:0] id,
                               logic [3:0] src, logic [31:0] stime, logic ack_pkt);
      while ($urandom_range(99) < tx_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= func;
      req_ch.peer        <= peer;
      req_ch.packet_id   <= id;
      req_ch.source_addr <= src;
      req_ch.start_time  <= stime;
      req_ch.is_ack      <= ack_pkt;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random;
      int roll;
      logic [1:0]  func;
      logic [3:0]  peer;
      logic [15:0] id;
      roll = $urandom_range(99);
      if (roll < 55) func = FUNC_INJECT;
      else if (roll < 75) func = FUNC_ACK;
      else if (roll < 95) func = FUNC_TICK;
      else func = FUNC_UNUSED;
      // crowd a few peers so queues fill and acks find their ids
      peer = ($urandom_range(99) < 70) ? 4'($urandom_range(3)) : 4'($urandom);
      id = ($urandom_range(99) < 80) ? 16'($urandom_range(11)) : 16'($urandom);
      send_request(func, peer, id, 4'($urandom), $urandom, $urandom_range(99) < 8);
   endtask

   // hold until the block has drained, then give it time to finish silent work
   task automatic wait_drained;
      req_ch.valid <= 1'b0;
      // let the checker see the last request transfer first
      @(posedge clock);
      while (resends_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      logic [15:0] limits [6];
      limits = '{16'd1, 16'd65535, 16'd3, 16'd2, 16'd1024, 16'd6};
      cycle_count = 0;
      tx_idle = 18;
      rx_idle = 45;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_INJECT;
      req_ch.peer = '0;
      req_ch.packet_id = '0;
      req_ch.source_addr = '0;
      req_ch.start_time = '0;
      req_ch.is_ack = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: duplicates, ack packets, full queue, acks at head, middle and miss
      write_limit(16'd2);
      send_request(FUNC_INJECT, 4'd0, 16'h0000, 4'h0, 32'h0000_0000, 1'b0);
      send_request(FUNC_INJECT, 4'd0, 16'h0000, 4'hf, 32'hffff_ffff, 1'b0);
      send_request(FUNC_INJECT, 4'd0, 16'h0001, 4'h3, 32'h1234_5678, 1'b1);
      for (int k = 0; k < QUEUE_DEPTH + 1; k++)
         send_request(FUNC_INJECT, 4'd15, 16'hfff0 + 16'(k), 4'(k), 32'hffff_ff00 + k, 1'b0);
      send_request(FUNC_ACK, 4'd15, 16'hfff3, 4'h0, 32'h0, 1'b0);
      send_request(FUNC_ACK, 4'd15, 16'hfff0, 4'h0, 32'h0, 1'b0);
      send_request(FUNC_ACK, 4'd15, 16'h7777, 4'h0, 32'h0, 1'b0);
      send_request(FUNC_UNUSED, 4'd0, 16'hffff, 4'hf, 32'hffff_ffff, 1'b1);
      send_request(FUNC_TICK, 4'd0, 16'h0, 4'h0, 32'h0, 1'b0);
      send_request(FUNC_TICK, 4'd0, 16'h0, 4'h0, 32'h0, 1'b0);
      send_request(FUNC_ACK, 4'd0, 16'h0000, 4'h0, 32'h0, 1'b0);
      send_request(FUNC_TICK, 4'd0, 16'h0, 4'h0, 32'h0, 1'b0);
      send_request(FUNC_TICK, 4'd0, 16'h0, 4'h0, 32'h0, 1'b0);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         write_limit(limits[p]);
         tx_idle = (p / 2 == 0) ? 18 : (p / 2 == 1) ? 45 : 0;
         rx_idle = (p / 2 == 0) ? 45 : (p / 2 == 1) ? 18 : 0;
         repeat (15) send_random();
         wait_drained();
      end

      if (fail_count == 0)
         $display("tb_end_to_end_retransmit_tracker_top OK");
      else
         $display("tb_end_to_end_retransmit_tracker_top NOT OK");
      $finish;
   end
endmodule

[end_to_end_retransmit_tracker_top.f]
+incdir+rtl
rtl/e2e_rtt_pkg.sv
rtl/e2e_rtt_ifs.sv
rtl/e2e_rtt_datapath.sv
rtl/e2e_rtt_ctrl.sv
rtl/end_to_end_retransmit_tracker_top.sv
rtl/e2e_rtt_checker.sv
bench/e2e_rtt_tracker_checker.sv
bench/tb_end_to_end_retransmit_tracker_top.sv
